// ===== hdl/bpfa_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap page frame allocator package
// Sizes, codes and state type shared by the allocator and its channels.
// ----------------------------------------------------------------------------
package bpfa_pkg;

	localparam int MAX_FRAMES  = 512;
	localparam int PAGE_BYTES  = 4096;
	localparam int WORD_BITS   = 64;
	localparam int ADDR_W      = 64;
	localparam int COUNT_W     = 10;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 64;
	localparam int STATUS_W    = 2;

	localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
	localparam int PAGE_NUM_W  = ADDR_W - PAGE_SHIFT;
	localparam int MAP_WORDS   = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int WORD_IDX_W  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BIT_IDX_W   = $clog2(WORD_BITS);
	localparam int FRAME_IDX_W = WORD_IDX_W + BIT_IDX_W;
	localparam int ACT_W       = $clog2(MAX_FRAMES + 1);

	// Request kinds.
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK           = 2'd0,
		STATUS_NONE_FREE    = 2'd1,
		STATUS_OUT_OF_RANGE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALLOC_RD,
		ST_ALLOC_CHK,
		ST_FREE_SUB,
		ST_FREE_CHK,
		ST_FREE_WR,
		ST_FINISH
	} state_t;

endpackage

// ===== hdl/bpfa_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Allocator configuration channel
// Register write words: register index and write data.
// ----------------------------------------------------------------------------
interface bpfa_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [bpfa_pkg::CFG_IDX_W-1:0]     index;
	logic [bpfa_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/bpfa_req_if.sv =====
// ----------------------------------------------------------------------------
// Allocator request channel
// One word per allocate or free request.
// ----------------------------------------------------------------------------
interface bpfa_req_if;
	logic                           valid;
	logic                           ready;
	logic                           action;
	logic [bpfa_pkg::ADDR_W-1:0]    frame_address;

	modport source (output valid, action, frame_address, input ready);
	modport sink   (input valid, action, frame_address, output ready);
endinterface

// ===== hdl/bpfa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Allocator response channel
// One word per request: resulting address and status.
// ----------------------------------------------------------------------------
interface bpfa_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [bpfa_pkg::ADDR_W-1:0]    result_address;
	logic [bpfa_pkg::STATUS_W-1:0]  status;

	modport source (output valid, result_address, status, input ready);
	modport sink   (input valid, result_address, status, output ready);
endinterface

// ===== hdl/bitmap_page_frame_allocator_core.sv =====
// ----------------------------------------------------------------------------
// Bitmap page frame allocator core
// First-fit page frame allocator over a used-bit map held in a word memory.
// ----------------------------------------------------------------------------
// Usage:
//   cfg : register writes, always ready. Index 0 is the base address, index 1
//         the frame count. Write only while no request is in flight.
//   req : one word per request; action 0 allocates, action 1 frees the frame
//         that frame_address falls in.
//   rsp : exactly one word per request, in order.
// Sequencing: one request is handled at a time. The map lives in a memory
//   of 64-bit words with a registered read, and an allocation scans it one
//   word per cycle from word 0 until it finds a free frame, reading at most
//   8 words. A free steps through subtract, range check and read, write
//   back and finish, and skips the write back when it is ignored. The next
//   request can be accepted in the cycle after the response is loaded.
// Reset: every frame is free, base address 0, frame count 512. The map rows
//   carry valid bits cleared at reset, so no clearing pass is needed.
// Stall: the response sits in an output register; the next request is taken
//   while it waits, and the core holds its finished result until the
//   output register is free.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator_core (
	input  logic          clk,
	input  logic          arst_n,
	bpfa_cfg_if.sink      cfg,
	bpfa_req_if.sink      req,
	bpfa_rsp_if.source    rsp
);

	bpfa_pkg::state_t state_q, state_d;

	logic [bpfa_pkg::ADDR_W-1:0]       base_q;
	logic [bpfa_pkg::COUNT_W-1:0]      count_q;
	logic [bpfa_pkg::ACT_W-1:0]        act_n;

	logic                              action_q;
	logic [bpfa_pkg::ADDR_W-1:0]       addr_q;
	logic                              below_q;
	logic [bpfa_pkg::PAGE_NUM_W-1:0]   page_q;
	logic [bpfa_pkg::WORD_IDX_W-1:0]   scan_ptr_q;
	logic [bpfa_pkg::FRAME_IDX_W-1:0]  hit_idx_q;
	logic                              alloc_ok_q;
	bpfa_pkg::status_t                 status_q, status_d;
	logic                              status_ld;

	logic                              rsp_valid_q;
	logic [bpfa_pkg::ADDR_W-1:0]       rsp_addr_q;
	bpfa_pkg::status_t                 rsp_status_q;

	// Map memory and per-row valid bits.
	logic [bpfa_pkg::WORD_BITS-1:0]    map_mem [bpfa_pkg::MAP_WORDS];
	logic [bpfa_pkg::MAP_WORDS-1:0]    row_valid_q;
	logic [bpfa_pkg::WORD_BITS-1:0]    rd_data_s1;
	logic                              rd_valid_s1;
	logic [bpfa_pkg::WORD_BITS-1:0]    rd_word;

	logic                              rd_en, wr_en;
	logic [bpfa_pkg::WORD_IDX_W-1:0]   rd_addr, wr_addr;
	logic [bpfa_pkg::WORD_BITS-1:0]    wr_data;

	logic [bpfa_pkg::WORD_BITS-1:0]    scan_mask, scan_free;
	logic [bpfa_pkg::BIT_IDX_W-1:0]    scan_pos;
	logic                              scan_hit, scan_last;
	logic                              page_oor;
	logic [bpfa_pkg::WORD_IDX_W-1:0]   page_word;
	logic [bpfa_pkg::BIT_IDX_W-1:0]    page_bit;
	logic                              req_fire, out_free;

	assign req_fire  = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == bpfa_pkg::ST_IDLE);

	assign rsp.valid          = rsp_valid_q;
	assign rsp.result_address = rsp_addr_q;
	assign rsp.status         = rsp_status_q;

	assign act_n = (32'(count_q) >= 32'(bpfa_pkg::MAX_FRAMES)) ?
		bpfa_pkg::ACT_W'(bpfa_pkg::MAX_FRAMES) : bpfa_pkg::ACT_W'(count_q);

	assign rd_word   = rd_valid_s1 ? rd_data_s1 : '0;
	assign page_oor  = 64'(page_q) >= 64'(act_n);
	assign page_word = page_q[bpfa_pkg::FRAME_IDX_W-1:bpfa_pkg::BIT_IDX_W];
	assign page_bit  = page_q[bpfa_pkg::BIT_IDX_W-1:0];
	assign scan_last = (32'(scan_ptr_q) == 32'(bpfa_pkg::MAP_WORDS - 1));

	// Frames at or beyond the active count never count as free.
	always_comb begin
		for (int b = 0; b < bpfa_pkg::WORD_BITS; b++) begin
			scan_mask[b] = (32'({scan_ptr_q, bpfa_pkg::BIT_IDX_W'(b)}) < 32'(act_n));
		end
	end

	assign scan_free = ~rd_word & scan_mask;
	assign scan_hit  = |scan_free;

	always_comb begin
		scan_pos = '0;
		for (int b = bpfa_pkg::WORD_BITS - 1; b >= 0; b--) begin
			if (scan_free[b]) begin
				scan_pos = bpfa_pkg::BIT_IDX_W'(b);
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			bpfa_pkg::ST_IDLE: begin
				if (req_fire) begin
					state_d = (req.action == bpfa_pkg::ACT_ALLOC) ?
						bpfa_pkg::ST_ALLOC_RD : bpfa_pkg::ST_FREE_SUB;
				end
			end
			bpfa_pkg::ST_ALLOC_RD:  state_d = bpfa_pkg::ST_ALLOC_CHK;
			bpfa_pkg::ST_ALLOC_CHK: begin
				if (scan_hit || scan_last) begin
					state_d = bpfa_pkg::ST_FINISH;
				end
			end
			bpfa_pkg::ST_FREE_SUB:  state_d = bpfa_pkg::ST_FREE_CHK;
			bpfa_pkg::ST_FREE_CHK: begin
				state_d = (below_q || page_oor) ? bpfa_pkg::ST_FINISH : bpfa_pkg::ST_FREE_WR;
			end
			bpfa_pkg::ST_FREE_WR:   state_d = bpfa_pkg::ST_FINISH;
			bpfa_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = bpfa_pkg::ST_IDLE;
				end
			end
			default:                state_d = bpfa_pkg::ST_IDLE;
		endcase
	end

	// Memory controls and status.
	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_addr   = scan_ptr_q;
		wr_data   = rd_word;
		status_ld = 1'b0;
		status_d  = bpfa_pkg::STATUS_OK;
		case (state_q)
			bpfa_pkg::ST_ALLOC_RD: begin
				rd_en = 1'b1;
			end
			bpfa_pkg::ST_ALLOC_CHK: begin
				if (scan_hit) begin
					wr_en     = 1'b1;
					wr_data   = rd_word | (bpfa_pkg::WORD_BITS'(1) << scan_pos);
					status_ld = 1'b1;
				end else if (scan_last) begin
					status_ld = 1'b1;
					status_d  = bpfa_pkg::STATUS_NONE_FREE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = scan_ptr_q + 1'b1;
				end
			end
			bpfa_pkg::ST_FREE_CHK: begin
				status_ld = 1'b1;
				if (!below_q && page_oor) begin
					status_d = bpfa_pkg::STATUS_OUT_OF_RANGE;
				end
				if (!below_q && !page_oor) begin
					rd_en   = 1'b1;
					rd_addr = page_word;
				end
			end
			bpfa_pkg::ST_FREE_WR: begin
				wr_en   = 1'b1;
				wr_addr = page_word;
				wr_data = rd_word & ~(bpfa_pkg::WORD_BITS'(1) << page_bit);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bpfa_pkg::ST_IDLE;
			base_q      <= '0;
			count_q     <= bpfa_pkg::COUNT_W'(512);
			row_valid_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					bpfa_pkg::REG_BASE_ADDRESS: base_q  <= cfg.data;
					bpfa_pkg::REG_FRAME_COUNT:  count_q <= cfg.data[bpfa_pkg::COUNT_W-1:0];
					default: begin
					end
				endcase
			end
			if (wr_en) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
			if (state_q == bpfa_pkg::ST_FINISH && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			action_q   <= req.action;
			addr_q     <= req.frame_address;
			scan_ptr_q <= '0;
			alloc_ok_q <= 1'b0;
		end
		if (state_q == bpfa_pkg::ST_FREE_SUB) begin
			below_q <= addr_q < base_q;
			page_q  <= bpfa_pkg::PAGE_NUM_W'((addr_q - base_q) >> bpfa_pkg::PAGE_SHIFT);
		end
		if (state_q == bpfa_pkg::ST_ALLOC_CHK) begin
			if (scan_hit) begin
				hit_idx_q  <= bpfa_pkg::FRAME_IDX_W'({scan_ptr_q, scan_pos});
				alloc_ok_q <= 1'b1;
			end else if (!scan_last) begin
				scan_ptr_q <= scan_ptr_q + 1'b1;
			end
		end
		if (status_ld) begin
			status_q <= status_d;
		end
		if (state_q == bpfa_pkg::ST_FINISH && out_free) begin
			rsp_status_q <= status_q;
			rsp_addr_q   <= (alloc_ok_q && action_q == bpfa_pkg::ACT_ALLOC) ?
				base_q + (bpfa_pkg::ADDR_W'(hit_idx_q) << bpfa_pkg::PAGE_SHIFT) : '0;
		end
	end

	// Map memory with a registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1  <= map_mem[rd_addr];
			rd_valid_s1 <= row_valid_q[rd_addr];
		end
	end

	// An address is only returned together with a good status.
	a_addr_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != bpfa_pkg::STATUS_OK |-> rsp.result_address == '0)
		else $error("nonzero address with failing status");

	// The map is only written by an allocate hit or a free write-back.
	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q == bpfa_pkg::ST_ALLOC_CHK || state_q == bpfa_pkg::ST_FREE_WR)
		else $error("map written outside an update state");

	// An allocation sets exactly one bit that was clear.
	a_alloc_one_bit: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && state_q == bpfa_pkg::ST_ALLOC_CHK |->
			$countones(wr_data ^ rd_word) == 1 && (wr_data & ~rd_word) != '0)
		else $error("allocation changed other than one free bit");

	// An accepted request leaves idle, so no second request slips in.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> !req.ready)
		else $error("request accepted while a request is in flight");

	// A finished result is moved out only when the output register is free.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp.ready |=> rsp_valid_q && $stable(rsp_addr_q))
		else $error("pending response overwritten");

endmodule

// ===== verif/bitmap_page_frame_allocator_core_tb.sv =====
// ----------------------------------------------------------------------------
// Bitmap page frame allocator core testbench
// Sends allocate and free requests, predicts each response from its own copy
// of the used map and registers, and compares every response word in order.
// Directed tests cover the corner cases. Random phases then change the base
// address and frame count between runs, fill the map, and stall both sides.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [bpfa_pkg::ADDR_W-1:0] result_address;
		bpfa_pkg::status_t           status;
	} frame_result_t;

	logic clk;
	logic arst_n;

	bpfa_cfg_if cfg_bus();
	bpfa_req_if req_bus();
	bpfa_rsp_if rsp_bus();

	bitmap_page_frame_allocator_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	// Predicted allocator state.
	logic [bpfa_pkg::MAX_FRAMES-1:0] used_frames = '0;
	logic [bpfa_pkg::ADDR_W-1:0]     base_reg    = '0;
	logic [bpfa_pkg::COUNT_W-1:0]    count_reg   = bpfa_pkg::COUNT_W'(512);

	frame_result_t frame_results_due[$];
	int            error_count = 0;

	// Idle controls for the request side and the response side; idle_off turns off both.
	int unsigned req_gap_pct   = 20;
	int unsigned rsp_stall_pct = 5;
	bit          idle_off      = 1'b0;

	initial begin
		clk = 1'b0;
	end

	always #6 clk = ~clk;

	function automatic int unsigned active_frames();
		return (count_reg < bpfa_pkg::MAX_FRAMES) ? int'(count_reg) : bpfa_pkg::MAX_FRAMES;
	endfunction

	function automatic frame_result_t predict_frame_op(input logic act,
			input logic [bpfa_pkg::ADDR_W-1:0] addr);
		frame_result_t r;
		int unsigned   limit;
		int unsigned   i;
		logic [bpfa_pkg::ADDR_W-1:0] page;
		r.result_address = '0;
		r.status = bpfa_pkg::STATUS_OK;
		limit = active_frames();
		if (act == bpfa_pkg::ACT_ALLOC) begin
			r.status = bpfa_pkg::STATUS_NONE_FREE;
			for (i = 0; i < limit && r.status == bpfa_pkg::STATUS_NONE_FREE; i++) begin
				if (!used_frames[i]) begin
					used_frames[i] = 1'b1;
					r.result_address = base_reg + 64'(i) * 64'(bpfa_pkg::PAGE_BYTES);
					r.status = bpfa_pkg::STATUS_OK;
				end
			end
		end else if (addr >= base_reg) begin
			page = (addr - base_reg) / 64'(bpfa_pkg::PAGE_BYTES);
			if (page >= 64'(limit))
				r.status = bpfa_pkg::STATUS_OUT_OF_RANGE;
			else
				used_frames[page] = 1'b0;
		end
		return r;
	endfunction

	// Leaves valid high, unless a random gap is drawn, so that a following request keeps it up without a dip.
	task automatic send_request(input logic act, input logic [bpfa_pkg::ADDR_W-1:0] addr);
		req_bus.valid         <= 1'b1;
		req_bus.action        <= act;
		req_bus.frame_address <= addr;
		@(posedge clk);
		while (!req_bus.ready)
			@(posedge clk);
		frame_results_due.push_back(predict_frame_op(act, addr));
		if (!idle_off && $urandom_range(0, 99) < req_gap_pct) begin
			req_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 18))
				@(posedge clk);
		end
	endtask

	task automatic write_register(input logic [bpfa_pkg::CFG_IDX_W-1:0] idx,
			input logic [bpfa_pkg::CFG_DATA_W-1:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		if (idx == bpfa_pkg::REG_BASE_ADDRESS)
			base_reg = value;
		else
			count_reg = value[bpfa_pkg::COUNT_W-1:0];
	endtask

	// Upper bits of the count word are junk; only the low bits take effect.
	task automatic configure(input logic [bpfa_pkg::ADDR_W-1:0] base,
			input int unsigned count);
		logic [bpfa_pkg::CFG_DATA_W-1:0] count_word;
		count_word = {$urandom, $urandom};
		count_word[bpfa_pkg::COUNT_W-1:0] = bpfa_pkg::COUNT_W'(count);
		write_register(bpfa_pkg::REG_BASE_ADDRESS, base);
		write_register(bpfa_pkg::REG_FRAME_COUNT, count_word);
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		req_bus.valid <= 1'b0;
		do
			@(posedge clk);
		while (frame_results_due.size() != 0);
	endtask

	task automatic test_alloc_free_basics();
		send_request(bpfa_pkg::ACT_ALLOC, '0);
		send_request(bpfa_pkg::ACT_ALLOC, '1);
		send_request(bpfa_pkg::ACT_ALLOC, 64'h5A5A_A5A5_0F0F_F0F0);
		send_request(bpfa_pkg::ACT_FREE, 64'h1FFF);
		// The same frame again: already free, the bit stays clear.
		send_request(bpfa_pkg::ACT_FREE, 64'h1000);
		send_request(bpfa_pkg::ACT_ALLOC, '0);
		send_request(bpfa_pkg::ACT_FREE, '1);
		send_request(bpfa_pkg::ACT_FREE, '0);
		wait_drained();
	endtask

	task automatic test_count_limits();
		configure(64'h0000_0000_0010_0000, 3);
		send_request(bpfa_pkg::ACT_ALLOC, '0);
		send_request(bpfa_pkg::ACT_ALLOC, '0);
		send_request(bpfa_pkg::ACT_FREE, 64'h0000_0000_000F_FFFF);
		send_request(bpfa_pkg::ACT_FREE, 64'h0000_0000_0010_3000);
		wait_drained();
		configure(64'h0000_0000_0010_0000, 0);
		send_request(bpfa_pkg::ACT_ALLOC, '0);
		send_request(bpfa_pkg::ACT_FREE, 64'h0000_0000_0010_0000);
		wait_drained();
	endtask

	task automatic test_address_wrap();
		configure(64'hFFFF_FFFF_FFFF_E000, 1023);
		send_request(bpfa_pkg::ACT_ALLOC, '0);
		send_request(bpfa_pkg::ACT_ALLOC, '0);
		// Frame 1 sits at the very top of the address space.
		send_request(bpfa_pkg::ACT_FREE, 64'hFFFF_FFFF_FFFF_F123);
		send_request(bpfa_pkg::ACT_FREE, 64'h0000_0000_0000_1000);
		send_request(bpfa_pkg::ACT_ALLOC, '0);
		wait_drained();
	endtask

	task automatic random_request(input int unsigned alloc_pct);
		logic                        act;
		logic [bpfa_pkg::ADDR_W-1:0] addr;
		int unsigned                 limit;
		int unsigned                 idx;
		int unsigned                 pick;
		int unsigned                 t;
		act = ($urandom_range(0, 99) < alloc_pct) ? bpfa_pkg::ACT_ALLOC : bpfa_pkg::ACT_FREE;
		addr = {$urandom, $urandom};
		limit = active_frames();
		pick = $urandom_range(0, 99);
		if (act == bpfa_pkg::ACT_FREE) begin
			if (pick < 80 && limit > 0) begin
				// Prefer a frame that is in use so that frees change the map.
				idx = $urandom_range(0, limit - 1);
				for (t = 0; t < 6 && !used_frames[idx]; t++)
					idx = $urandom_range(0, limit - 1);
				addr = base_reg + 64'(idx) * 64'(bpfa_pkg::PAGE_BYTES)
					+ 64'($urandom_range(0, bpfa_pkg::PAGE_BYTES - 1));
			end else if (pick < 90) begin
				idx = limit + $urandom_range(0, 40);
				addr = base_reg + 64'(idx) * 64'(bpfa_pkg::PAGE_BYTES)
					+ 64'($urandom_range(0, bpfa_pkg::PAGE_BYTES - 1));
			end else if (pick < 95) begin
				addr = base_reg - 64'($urandom_range(1, 1 << 20));
			end
		end
		send_request(act, addr);
	endtask

	task automatic test_random_phases();
		int unsigned counts[8];
		int unsigned items[8];
		int unsigned alloc_pcts[8];
		int unsigned gap_pcts[8];
		int unsigned stall_pcts[8];
		logic [bpfa_pkg::ADDR_W-1:0] base;
		int unsigned p;
		int unsigned n;
		counts     = '{1023, 512, 512, 5, 0, 300, 1, 512};
		items      = '{280, 180, 140, 70, 30, 110, 40, 100};
		alloc_pcts = '{95, 85, 90, 50, 50, 30, 50, 60};
		gap_pcts   = '{0, 25, 10, 40, 20, 5, 30, 0};
		stall_pcts = '{0, 10, 3, 15, 8, 2, 12, 0};
		for (p = 0; p < 8; p++) begin
			case (p)
				0, 6: begin
					base = {$urandom, $urandom};
					base[bpfa_pkg::PAGE_SHIFT-1:0] = '0;
				end
				// Frame 200 lands on address zero.
				1: base = 64'(0) - 64'(200 * bpfa_pkg::PAGE_BYTES);
				3: base = {$urandom, $urandom};
				4: base = '1;
				default: base = '0;
			endcase
			configure(base, counts[p]);
			req_gap_pct   = gap_pcts[p];
			rsp_stall_pct = stall_pcts[p];
			idle_off      = (p == 7);
			for (n = 0; n < items[p]; n++)
				random_request(alloc_pcts[p]);
			wait_drained();
		end
	endtask

	// Response side: ready drops for random bursts unless idling is off.
	initial begin
		rsp_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!idle_off && $urandom_range(0, 99) < rsp_stall_pct) begin
				rsp_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 18))
					@(posedge clk);
			end
			rsp_bus.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		frame_result_t due;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (frame_results_due.size() == 0) begin
				$error("response word with no request outstanding: result_address %h status %0d",
					rsp_bus.result_address, rsp_bus.status);
				error_count++;
			end else begin
				due = frame_results_due.pop_front();
				if (rsp_bus.result_address !== due.result_address) begin
					$error("result_address: expected %h, actual %h",
						due.result_address, rsp_bus.result_address);
					error_count++;
				end
				if (rsp_bus.status !== due.status) begin
					$error("status: expected %0d, actual %0d", due.status, rsp_bus.status);
					error_count++;
				end
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT)
			@(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		arst_n                <= 1'b0;
		cfg_bus.valid         <= 1'b0;
		cfg_bus.index         <= bpfa_pkg::REG_BASE_ADDRESS;
		cfg_bus.data          <= '0;
		req_bus.valid         <= 1'b0;
		req_bus.action        <= bpfa_pkg::ACT_ALLOC;
		req_bus.frame_address <= '0;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_alloc_free_basics();
		test_count_limits();
		test_address_wrap();
		test_random_phases();

		repeat (16)
			@(posedge clk);
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/bpfa_pkg.sv
hdl/bpfa_cfg_if.sv
hdl/bpfa_req_if.sv
hdl/bpfa_rsp_if.sv
hdl/bitmap_page_frame_allocator_core.sv
verif/bitmap_page_frame_allocator_core_tb.sv
